### design/salfu_pkg.sv
// Shared types and constants for the set-associative LFU cache.
// Operation codes, configuration layout, sequencer states and status records.
// No dependencies.
package salfu_pkg;

    localparam int ADDR_W = 12;
    localparam int DATA_W = 8;
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_SET_BITS   = 2'd0;
    localparam logic [1:0] REG_TAG_BITS   = 2'd1;
    localparam logic [1:0] REG_BLOCK_BITS = 2'd2;
    localparam logic [1:0] REG_WAYS       = 2'd3;

    // reset values of the configuration registers
    localparam logic [2:0] RST_SET_BITS   = 3'd2;
    localparam logic [3:0] RST_TAG_BITS   = 4'd8;
    localparam logic [1:0] RST_BLOCK_BITS = 2'd2;
    localparam logic [2:0] RST_WAYS       = 3'd4;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef struct packed {
        logic [2:0] set_bits;
        logic [3:0] tag_bits;
        logic [1:0] block_bits;
        logic [2:0] ways;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WAY_RD,
        ST_WAY_CMP,
        ST_HIT_UPD,
        ST_HIT_BYTE,
        ST_FILL_RD,
        ST_FILL_WR,
        ST_MISS_UPD,
        ST_DONE
    } seq_state_t;

    // sequencer status toward the top level
    typedef struct packed {
        logic              idle;
        logic              res_valid;
        logic [DATA_W-1:0] read_data;
        logic              hit;
    } seq_stat_t;

endpackage

### design/salfu_way_cmp.sv
// Shared way compare unit: tag match and least-use-count selection for one way.
// Used once per way during the set scan. Depends on salfu_pkg.
module salfu_way_cmp #(
    parameter int COUNT_BITS = 16
) (
    input  logic                          line_valid,
    input  logic [salfu_pkg::ADDR_W-1:0]  line_tag,
    input  logic [salfu_pkg::ADDR_W-1:0]  key_tag,
    input  logic [COUNT_BITS-1:0]         line_count,
    input  logic [COUNT_BITS-1:0]         best_count,
    input  logic                          first,
    output logic                          match,
    output logic [COUNT_BITS-1:0]         eff_count,
    output logic                          take
);
    import salfu_pkg::*;

    // invalid ways count as zero use
    assign match     = line_valid && (line_tag == key_tag);
    assign eff_count = line_valid ? line_count : '0;
    // strict less-than keeps the first way holding the minimum
    assign take      = first || (eff_count < best_count);

endmodule

### design/salfu_seq.sv
// Cache sequencer: way scan, hit update, block fill, plus the tag, count,
// line byte and backing memories. Depends on salfu_pkg and salfu_way_cmp.
module salfu_seq #(
    parameter int MAX_SET_BITS   = 4,
    parameter int NUM_WAYS       = 4,
    parameter int MAX_BLOCK_BITS = 2,
    parameter int MEM_BYTES      = 4096,
    parameter int COUNT_BITS     = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  salfu_pkg::cfg_t              cfg,
    input  logic                         in_valid,
    input  salfu_pkg::op_t               in_op,
    input  logic [salfu_pkg::ADDR_W-1:0] in_addr,
    input  logic [salfu_pkg::DATA_W-1:0] in_data,
    input  logic                         res_ready,
    output salfu_pkg::seq_stat_t         stat
);
    import salfu_pkg::*;

    localparam int NSETS   = 1 << MAX_SET_BITS;
    localparam int NLINES  = NSETS * NUM_WAYS;
    localparam int BLK_MAX = 1 << MAX_BLOCK_BITS;
    localparam int NBYTES  = NLINES * BLK_MAX;
    localparam int LINE_W  = (NLINES > 1) ? $clog2(NLINES) : 1;
    localparam int BYTE_W  = LINE_W + MAX_BLOCK_BITS;
    localparam int WAY_W   = $clog2(NUM_WAYS + 1);
    localparam int SET_W   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int J_W     = MAX_BLOCK_BITS + 1;
    localparam int MEM_AW  = $clog2(MEM_BYTES);

    // control
    seq_state_t state_reg, state_next;

    // item context
    op_t               op_reg, op_next;
    logic [SET_W-1:0]  set_reg, set_next;
    logic [ADDR_W-1:0] tag_reg, tag_next;
    logic [J_W-1:0]    boff_reg, boff_next;
    logic [J_W-1:0]    blen_reg, blen_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic [WAY_W-1:0]  ways_reg, ways_next;

    // scan and fill progress
    logic [WAY_W-1:0]      way_reg, way_next;
    logic                  hit_reg, hit_next;
    logic [WAY_W-1:0]      hit_way_reg, hit_way_next;
    logic [COUNT_BITS-1:0] hit_cnt_reg, hit_cnt_next;
    logic [WAY_W-1:0]      best_way_reg, best_way_next;
    logic [COUNT_BITS-1:0] best_cnt_reg, best_cnt_next;
    logic [J_W-1:0]        j_reg, j_next;
    logic [DATA_W-1:0]     rd_reg, rd_next;

    // valid bits, cleared by reset
    logic [NLINES-1:0] line_valid_reg, line_valid_next;
    logic [NBYTES-1:0] byte_valid_reg, byte_valid_next;

    // memories
    logic [ADDR_W-1:0]     tag_mem  [NLINES];
    logic [COUNT_BITS-1:0] cnt_mem  [NLINES];
    logic [DATA_W-1:0]     byte_mem [NBYTES];
    logic [DATA_W-1:0]     back_mem [MEM_BYTES];

    logic [ADDR_W-1:0]     tag_rd_reg;
    logic [COUNT_BITS-1:0] cnt_rd_reg;
    logic                  lvalid_rd_reg;
    logic [DATA_W-1:0]     byte_rd_reg;
    logic                  bvalid_rd_reg;
    logic [DATA_W-1:0]     back_rd_reg;

    // memory controls
    logic [LINE_W-1:0]     meta_raddr;
    logic                  tag_we;
    logic                  cnt_we;
    logic [LINE_W-1:0]     meta_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic                  lvalid_set;
    logic                  byte_we;
    logic [BYTE_W-1:0]     byte_waddr;
    logic [DATA_W-1:0]     byte_wdata;
    logic [BYTE_W-1:0]     byte_raddr;
    logic                  back_we;
    logic [MEM_AW-1:0]     back_waddr;
    logic [MEM_AW-1:0]     back_raddr;

    // address split at accept
    logic [3:0]        sb_c;
    logic [2:0]        bb_c;
    logic [3:0]        tb_c;
    logic [4:0]        sh_c;
    logic [ADDR_W-1:0] bmask_c;
    logic [ADDR_W-1:0] smask_c;
    logic [ADDR_W-1:0] tmask_c;
    logic [WAY_W-1:0]  ways_c;

    // compare unit
    logic                  cmp_match;
    logic [COUNT_BITS-1:0] cmp_eff;
    logic                  cmp_take;
    logic                  last_way;
    logic                  last_byte;
    logic [LINE_W-1:0]     hit_line;
    logic [LINE_W-1:0]     best_line;
    logic [COUNT_BITS-1:0] hit_cnt_bump;

    function automatic logic [LINE_W-1:0] line_of(input logic [SET_W-1:0] s,
                                                  input logic [WAY_W-1:0] w);
        return LINE_W'(LINE_W'(s) * LINE_W'(NUM_WAYS) + LINE_W'(w));
    endfunction

    function automatic logic [BYTE_W-1:0] byte_of(input logic [LINE_W-1:0] l,
                                                  input logic [J_W-1:0] j);
        return (BYTE_W'(l) << MAX_BLOCK_BITS) | BYTE_W'(j);
    endfunction

    // clamp the configuration and split the incoming address
    always_comb begin
        sb_c = (cfg.set_bits > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : {1'b0, cfg.set_bits};
        bb_c = (cfg.block_bits > MAX_BLOCK_BITS) ? 3'(MAX_BLOCK_BITS)
                                                 : {1'b0, cfg.block_bits};
        tb_c = (cfg.tag_bits > ADDR_W) ? 4'(ADDR_W) : cfg.tag_bits;
        sh_c = 5'(bb_c) + 5'(sb_c);
        bmask_c = (ADDR_W'(1) << bb_c) - ADDR_W'(1);
        smask_c = (ADDR_W'(1) << sb_c) - ADDR_W'(1);
        tmask_c = (ADDR_W'(1) << tb_c) - ADDR_W'(1);
        if (cfg.ways == 3'd0) begin
            ways_c = WAY_W'(1);
        end else if (cfg.ways > NUM_WAYS) begin
            ways_c = WAY_W'(NUM_WAYS);
        end else begin
            ways_c = WAY_W'(cfg.ways);
        end
    end

    salfu_way_cmp #(
        .COUNT_BITS (COUNT_BITS)
    ) u_cmp (
        .line_valid (lvalid_rd_reg),
        .line_tag   (tag_rd_reg),
        .key_tag    (tag_reg),
        .line_count (cnt_rd_reg),
        .best_count (best_cnt_reg),
        .first      (way_reg == '0),
        .match      (cmp_match),
        .eff_count  (cmp_eff),
        .take       (cmp_take)
    );

    assign last_way     = (way_reg == ways_reg - WAY_W'(1));
    assign last_byte    = (j_reg == blen_reg - J_W'(1));
    assign hit_line     = line_of(set_reg, hit_way_reg);
    assign best_line    = line_of(set_reg, best_way_reg);
    assign hit_cnt_bump = (hit_cnt_reg == '1) ? hit_cnt_reg
                                              : hit_cnt_reg + COUNT_BITS'(1);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    if (in_op == OP_READ || in_op == OP_WRITE) begin
                        state_next = ST_WAY_RD;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_WAY_RD: state_next = ST_WAY_CMP;
            ST_WAY_CMP: begin
                if (cmp_match) begin
                    state_next = ST_HIT_UPD;
                end else if (last_way) begin
                    state_next = (op_reg == OP_READ) ? ST_FILL_RD : ST_DONE;
                end else begin
                    state_next = ST_WAY_RD;
                end
            end
            ST_HIT_UPD:  state_next = (op_reg == OP_READ) ? ST_HIT_BYTE : ST_DONE;
            ST_HIT_BYTE: state_next = ST_DONE;
            ST_FILL_RD:  state_next = ST_FILL_WR;
            ST_FILL_WR:  state_next = last_byte ? ST_MISS_UPD : ST_FILL_RD;
            ST_MISS_UPD: state_next = ST_DONE;
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // memory controls and status
    always_comb begin
        meta_raddr = line_of(set_reg, way_reg);
        byte_raddr = byte_of(hit_line, boff_reg);
        back_raddr = MEM_AW'(base_reg | ADDR_W'(j_reg));
        back_waddr = MEM_AW'(in_addr);
        back_we    = 1'b0;
        tag_we     = 1'b0;
        cnt_we     = 1'b0;
        lvalid_set = 1'b0;
        byte_we    = 1'b0;
        meta_waddr = hit_line;
        cnt_wdata  = hit_cnt_bump;
        byte_waddr = byte_of(hit_line, boff_reg);
        byte_wdata = data_reg;
        case (state_reg)
            ST_IDLE: begin
                back_we = in_valid && (in_op == OP_LOAD || in_op == OP_WRITE);
            end
            ST_HIT_UPD: begin
                cnt_we  = 1'b1;
                byte_we = (op_reg == OP_WRITE);
            end
            ST_FILL_WR: begin
                byte_we    = 1'b1;
                byte_waddr = byte_of(best_line, j_reg);
                byte_wdata = back_rd_reg;
            end
            ST_MISS_UPD: begin
                tag_we     = 1'b1;
                cnt_we     = 1'b1;
                lvalid_set = 1'b1;
                meta_waddr = best_line;
                cnt_wdata  = COUNT_BITS'(1);
            end
            default: ;
        endcase
        stat.idle      = (state_reg == ST_IDLE);
        stat.res_valid = (state_reg == ST_DONE);
        stat.read_data = rd_reg;
        stat.hit       = hit_reg;
    end

    // item context and scan bookkeeping
    always_comb begin
        op_next       = op_reg;
        set_next      = set_reg;
        tag_next      = tag_reg;
        boff_next     = boff_reg;
        blen_next     = blen_reg;
        base_next     = base_reg;
        data_next     = data_reg;
        ways_next     = ways_reg;
        way_next      = way_reg;
        hit_next      = hit_reg;
        hit_way_next  = hit_way_reg;
        hit_cnt_next  = hit_cnt_reg;
        best_way_next = best_way_reg;
        best_cnt_next = best_cnt_reg;
        j_next        = j_reg;
        rd_next       = rd_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    op_next   = in_op;
                    set_next  = SET_W'((in_addr >> bb_c) & smask_c);
                    tag_next  = (in_addr >> sh_c) & tmask_c;
                    boff_next = J_W'(in_addr & bmask_c);
                    blen_next = J_W'(1) << bb_c;
                    base_next = in_addr & ~bmask_c;
                    data_next = in_data;
                    ways_next = ways_c;
                    way_next  = '0;
                    hit_next  = 1'b0;
                    j_next    = '0;
                    rd_next   = '0;
                end
            end
            ST_WAY_CMP: begin
                if (cmp_match) begin
                    hit_next     = 1'b1;
                    hit_way_next = way_reg;
                    hit_cnt_next = cnt_rd_reg;
                end
                if (cmp_take) begin
                    best_way_next = way_reg;
                    best_cnt_next = cmp_eff;
                end
                way_next = way_reg + WAY_W'(1);
            end
            ST_HIT_BYTE: begin
                rd_next = bvalid_rd_reg ? byte_rd_reg : '0;
            end
            ST_FILL_WR: begin
                if (j_reg == boff_reg) begin
                    rd_next = back_rd_reg;
                end
                j_next = j_reg + J_W'(1);
            end
            default: ;
        endcase
    end

    // valid bit updates
    always_comb begin
        line_valid_next = line_valid_reg;
        byte_valid_next = byte_valid_reg;
        if (lvalid_set) begin
            line_valid_next[meta_waddr] = 1'b1;
        end
        if (byte_we) begin
            byte_valid_next[byte_waddr] = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            line_valid_reg <= '0;
            byte_valid_reg <= '0;
        end else begin
            state_reg      <= state_next;
            line_valid_reg <= line_valid_next;
            byte_valid_reg <= byte_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        set_reg      <= set_next;
        tag_reg      <= tag_next;
        boff_reg     <= boff_next;
        blen_reg     <= blen_next;
        base_reg     <= base_next;
        data_reg     <= data_next;
        ways_reg     <= ways_next;
        way_reg      <= way_next;
        hit_reg      <= hit_next;
        hit_way_reg  <= hit_way_next;
        hit_cnt_reg  <= hit_cnt_next;
        best_way_reg <= best_way_next;
        best_cnt_reg <= best_cnt_next;
        j_reg        <= j_next;
        rd_reg       <= rd_next;
    end

    // tag and count memories, one line read per cycle
    always_ff @(posedge aclk) begin
        if (tag_we) begin
            tag_mem[meta_waddr] <= tag_reg;
        end
        if (cnt_we) begin
            cnt_mem[meta_waddr] <= cnt_wdata;
        end
        tag_rd_reg    <= tag_mem[meta_raddr];
        cnt_rd_reg    <= cnt_mem[meta_raddr];
        lvalid_rd_reg <= line_valid_reg[meta_raddr];
    end

    // line byte memory
    always_ff @(posedge aclk) begin
        if (byte_we) begin
            byte_mem[byte_waddr] <= byte_wdata;
        end
        byte_rd_reg   <= byte_mem[byte_raddr];
        bvalid_rd_reg <= byte_valid_reg[byte_raddr];
    end

    // backing memory, contents undefined until written
    always_ff @(posedge aclk) begin
        if (back_we) begin
            back_mem[back_waddr] <= in_data;
        end
        back_rd_reg <= back_mem[back_raddr];
    end

endmodule

### design/set_assoc_cache_lfu.sv
// Top level of the set-associative LFU cache: stream ports, APB register
// block and result register. Depends on salfu_pkg and salfu_seq.
//
//  Channel   Direction  Handshake          Payload
//  s_        in         s_tvalid/s_tready  s_tdata: address, write_data; s_tuser: operation
//  m_        out        m_tvalid/m_tready  m_tdata: read_data; m_tuser: hit
//  APB       in         psel/penable       set, tag, block bit counts and ways in use
//
// A load or unused operation goes straight to the result; a read or write
// scans the ways of its set until a tag match, and a read miss then fills
// the first least-used way from backing memory. The scan reads one way at a
// time through the single tag/count port, the fill one byte at a time
// through the single backing memory read port.
// Reset is synchronous and clears control and all line and byte valid bits
// at once; no clearing pass. A result waits in the output register, and the
// next transaction is accepted once the sequencer has handed its result over.
// MEM_BYTES must be a power of two.
module set_assoc_cache_lfu #(
    parameter int MAX_SET_BITS   = 4,
    parameter int NUM_WAYS       = 4,
    parameter int MAX_BLOCK_BITS = 2,
    parameter int MEM_BYTES      = 4096,
    parameter int COUNT_BITS     = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [23:0]                  s_tdata,   // [11:0] address, [19:12] write_data
    input  logic [1:0]                   s_tuser,   // [1:0] operation
    // result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [7:0]                   m_tdata,   // [7:0] read_data
    output logic                         m_tuser,   // [0] hit
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [salfu_pkg::APB_AW-1:0] paddr,
    input  logic [salfu_pkg::APB_DW-1:0] pwdata,
    output logic [salfu_pkg::APB_DW-1:0] prdata,
    output logic                         pready
);
    import salfu_pkg::*;

    cfg_t              cfg_reg, cfg_next;
    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_data_reg, m_data_next;
    logic              m_hit_reg, m_hit_next;

    seq_stat_t stat;
    logic      s_acc;
    logic      res_ready;
    logic      res_fire;
    logic      cfg_wr;

    assign s_tready  = stat.idle;
    assign s_acc     = s_tvalid && stat.idle;
    assign res_ready = !m_valid_reg || m_tready;
    assign res_fire  = stat.res_valid && res_ready;

    salfu_seq #(
        .MAX_SET_BITS   (MAX_SET_BITS),
        .NUM_WAYS       (NUM_WAYS),
        .MAX_BLOCK_BITS (MAX_BLOCK_BITS),
        .MEM_BYTES      (MEM_BYTES),
        .COUNT_BITS     (COUNT_BITS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_acc),
        .in_op     (op_t'(s_tuser)),
        .in_addr   (s_tdata[ADDR_W-1:0]),
        .in_data   (s_tdata[ADDR_W+DATA_W-1:ADDR_W]),
        .res_ready (res_ready),
        .stat      (stat)
    );

    // register writes
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            case (paddr[3:2])
                REG_SET_BITS:   cfg_next.set_bits   = pwdata[2:0];
                REG_TAG_BITS:   cfg_next.tag_bits   = pwdata[3:0];
                REG_BLOCK_BITS: cfg_next.block_bits = pwdata[1:0];
                REG_WAYS:       cfg_next.ways       = pwdata[2:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (paddr[3:2])
            REG_SET_BITS:   prdata = APB_DW'(cfg_reg.set_bits);
            REG_TAG_BITS:   prdata = APB_DW'(cfg_reg.tag_bits);
            REG_BLOCK_BITS: prdata = APB_DW'(cfg_reg.block_bits);
            REG_WAYS:       prdata = APB_DW'(cfg_reg.ways);
            default:        prdata = '0;
        endcase
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_hit_next   = m_hit_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (res_fire) begin
            m_valid_next = 1'b1;
            m_data_next  = stat.read_data;
            m_hit_next   = stat.hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.set_bits   <= RST_SET_BITS;
            cfg_reg.tag_bits   <= RST_TAG_BITS;
            cfg_reg.block_bits <= RST_BLOCK_BITS;
            cfg_reg.ways       <= RST_WAYS;
            m_valid_reg        <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_hit_reg  <= m_hit_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_hit_reg;

    // one transaction at a time through the sequencer
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> !s_tready)
        else $error("sequencer ready right after accepting a transaction");

    // no new transaction while a result is still held in the sequencer
    a_no_accept_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.res_valid |-> !s_tready)
        else $error("input ready while a result is pending");

    // a handed-over result shows up on the output
    a_result_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        res_fire |=> m_tvalid)
        else $error("result handed over but output not valid");

endmodule

### test/tb_top.sv
// Self-checking testbench for set_assoc_cache_lfu: streams loads, cached reads
// and writes through several register settings and checks every result.
// Depends on salfu_pkg and the set_assoc_cache_lfu RTL.
module tb_top;
    import salfu_pkg::*;

    localparam int ITEMS_TOTAL  = 1150;
    localparam int PHASES       = 11;
    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES  = 40;
    localparam int MAX_WAYS     = 4;
    localparam int BLK_BYTES    = 4;

    typedef struct packed {
        logic [7:0] read_data;
        logic       hit;
    } cache_result_t;

    // Shadow copy of the cache: predicts each result in acceptance order
    class lfu_cache_shadow;
        logic [2:0]  set_bits;
        logic [3:0]  tag_bits;
        logic [1:0]  block_bits;
        logic [2:0]  ways;
        bit          line_valid[64];
        logic [11:0] line_tag[64];
        logic [15:0] use_count[64];
        logic [7:0]  line_bytes[256];
        logic [7:0]  backing[4096];
        cache_result_t expected_results[$];
        int          n_mismatch;

        function new();
            set_bits   = RST_SET_BITS;
            tag_bits   = RST_TAG_BITS;
            block_bits = RST_BLOCK_BITS;
            ways       = RST_WAYS;
            n_mismatch = 0;
            foreach (line_valid[i]) begin
                line_valid[i] = 0;
                line_tag[i]   = '0;
                use_count[i]  = '0;
            end
            foreach (line_bytes[i]) line_bytes[i] = '0;
            foreach (backing[i]) backing[i] = '0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_SET_BITS:   set_bits   = value[2:0];
                REG_TAG_BITS:   tag_bits   = value[3:0];
                REG_BLOCK_BITS: block_bits = value[1:0];
                REG_WAYS:       ways       = value[2:0];
                default: ;
            endcase
        endfunction

        function int unsigned eff_block_bits();
            return (block_bits > 2) ? 2 : block_bits;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Predict the result of one accepted transaction
        function void take_request(op_t op, logic [11:0] addr, logic [7:0] data);
            int unsigned sbits, bbits, tbits, nw, blen, boff, set_i, tag;
            int unsigned w, hit_way, line, best, best_cnt, c, base;
            bit hit;
            cache_result_t res;
            sbits = (set_bits > 4) ? 4 : set_bits;
            bbits = eff_block_bits();
            tbits = (tag_bits > 12) ? 12 : tag_bits;
            nw    = (ways == 0) ? 1 : ((ways > MAX_WAYS) ? MAX_WAYS : ways);
            blen  = 1 << bbits;
            boff  = addr & (blen - 1);
            set_i = (addr >> bbits) & ((1 << sbits) - 1);
            tag   = (addr >> (bbits + sbits)) & ((1 << tbits) - 1);
            res   = '0;
            hit   = 0;
            hit_way = 0;
            line  = 0;
            // tag search over the active ways
            for (w = 0; w < nw; w++) begin
                line = set_i * MAX_WAYS + w;
                if (!hit && line_valid[line] && line_tag[line] == tag) begin
                    hit = 1;
                    hit_way = w;
                end
            end
            case (op)
                OP_LOAD: backing[addr] = data;
                OP_READ: begin
                    if (hit) begin
                        line = set_i * MAX_WAYS + hit_way;
                        if (use_count[line] != 16'hFFFF) use_count[line]++;
                    end else begin
                        // first way with the lowest count; invalid counts as 0
                        best = 0;
                        best_cnt = 0;
                        for (w = 0; w < nw; w++) begin
                            c = line_valid[set_i * MAX_WAYS + w] ?
                                use_count[set_i * MAX_WAYS + w] : 0;
                            if (w == 0 || c < best_cnt) begin
                                best_cnt = c;
                                best = w;
                            end
                        end
                        line = set_i * MAX_WAYS + best;
                        base = addr & ~(blen - 1);
                        for (w = 0; w < blen; w++)
                            line_bytes[line * BLK_BYTES + w] = backing[(base + w) % 4096];
                        line_tag[line]   = tag;
                        use_count[line]  = 16'd1;
                        line_valid[line] = 1;
                    end
                    res.read_data = line_bytes[line * BLK_BYTES + boff];
                    res.hit = hit;
                end
                OP_WRITE: begin
                    backing[addr] = data;
                    if (hit) begin
                        line = set_i * MAX_WAYS + hit_way;
                        line_bytes[line * BLK_BYTES + boff] = data;
                        if (use_count[line] != 16'hFFFF) use_count[line]++;
                    end
                    res.hit = hit;
                end
                default: ;
            endcase
            expected_results.push_back(res);
        endfunction

        task report(string what, int got, int want);
            $display("mismatch %s: got %0h, expected %0h", what, got, want);
            n_mismatch++;
        endtask

        // Compare one result transaction with the oldest prediction
        task check_response(logic [7:0] read_data, logic hit);
            cache_result_t want;
            if (expected_results.size() == 0) begin
                report("unexpected result", {read_data, hit}, 0);
            end else begin
                want = expected_results.pop_front();
                if (read_data !== want.read_data)
                    report("read_data", read_data, want.read_data);
                if (hit !== want.hit)
                    report("hit", hit, want.hit);
            end
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [11:0] address, [19:12] write_data
    logic [1:0]  s_tuser;   // [1:0] operation
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] read_data
    logic        m_tuser;   // [0] hit
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic        pready;

    lfu_cache_shadow shadow;
    bit          mem_loaded[4096];
    int          n_sent;
    int          results_seen;
    int          idle_cycles;
    int          stall_left;
    int          hold_left;
    bit          held_off;
    bit          calm_tx;
    bit          calm_rx;
    bit          quiet_tail;
    logic [11:0] hot_addr[16];

    set_assoc_cache_lfu u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // result side: check transactions, then pick next tready
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            shadow.check_response(m_tdata, m_tuser);
            results_seen++;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!held_off && results_seen >= 400 && s_tvalid) begin
            // long hold-off so the cache backs up into the input
            held_off = 1;
            hold_left = 240;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!calm_rx && !quiet_tail && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(0, 18);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // APB register write: setup then access
    task cfg_write(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow.set_reg(idx, value);
    endtask

    // One input transaction, then maybe a gap
    task send(op_t op, logic [11:0] addr, logic [7:0] data);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, data, addr};
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        shadow.take_request(op, addr, data);
        if (op == OP_LOAD || op == OP_WRITE) mem_loaded[addr] = 1;
        n_sent++;
        if (!calm_tx && !quiet_tail && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
    endtask

    // Cached read; first loads any not yet loaded byte of the block a miss would fetch
    task read_at(logic [11:0] addr);
        int unsigned blen, base, j;
        blen = 1 << shadow.eff_block_bits();
        base = addr & ~(blen - 1);
        for (j = 0; j < blen; j++)
            if (!mem_loaded[base + j])
                send(OP_LOAD, 12'(base + j), 8'($urandom_range(0, 255)));
        send(OP_READ, addr, 8'($urandom_range(0, 255)));
    endtask

    task random_item();
        logic [11:0] addr;
        int r;
        if ($urandom_range(0, 9) < 7)
            addr = hot_addr[$urandom_range(0, 15)] ^ 12'($urandom_range(0, 3));
        else
            addr = 12'($urandom_range(0, 4095));
        r = $urandom_range(0, 19);
        if (r < 3)
            send(OP_LOAD, addr, 8'($urandom_range(0, 255)));
        else if (r < 13)
            read_at(addr);
        else if (r < 18)
            send(OP_WRITE, addr, 8'($urandom_range(0, 255)));
        else if (r == 18)
            send(OP_NONE, addr, 8'($urandom_range(0, 255)));
        else
            read_at(addr);
    endtask

    // Wait until all predictions are matched and the cache is idle
    task drain();
        s_tvalid <= 1'b0;
        while (shadow.pending() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int phase_cfg[PHASES][4];
        int p, i;
        logic [5:0] low_a, low_b;
        shadow     = new();
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = OP_LOAD;
        m_tready   = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        n_sent     = 0;
        results_seen = 0;
        idle_cycles = 0;
        stall_left = 0;
        hold_left  = 0;
        held_off   = 0;
        calm_tx    = 0;
        calm_rx    = 0;
        quiet_tail = 0;
        foreach (mem_loaded[k]) mem_loaded[k] = 0;

        // set, tag, block bit counts and ways per phase; extremes first
        phase_cfg[1] = '{7, 15, 3, 0};
        phase_cfg[2] = '{0, 0, 0, 1};
        phase_cfg[3] = '{0, 12, 0, 4};
        phase_cfg[4] = '{4, 12, 2, 4};
        phase_cfg[5] = '{1, 3, 1, 7};
        phase_cfg[6] = '{3, 5, 0, 2};
        phase_cfg[7] = '{2, 8, 2, 4};
        for (p = 8; p < PHASES; p++)
            phase_cfg[p] = '{$urandom_range(0, 7), $urandom_range(0, 15),
                             $urandom_range(0, 3), $urandom_range(0, 7)};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                cfg_write(REG_SET_BITS,   phase_cfg[p][0]);
                cfg_write(REG_TAG_BITS,   phase_cfg[p][1]);
                cfg_write(REG_BLOCK_BITS, phase_cfg[p][2]);
                cfg_write(REG_WAYS,       phase_cfg[p][3]);
            end
            calm_tx = ($urandom_range(0, 3) == 0);
            calm_rx = ($urandom_range(0, 3) == 0);

            // a few addresses sharing low bits, so sets collide and lines age
            low_a = 6'($urandom_range(0, 63));
            low_b = 6'($urandom_range(0, 63));
            for (i = 0; i < 16; i++)
                hot_addr[i] = {6'($urandom_range(0, 63)), (i < 10) ? low_a : low_b};

            if (p == 0) begin
                // unused operation, write miss, read miss, read hit, write hit,
                // stale line after load, top of the address range
                send(OP_NONE, 12'hFFF, 8'hFF);
                send(OP_WRITE, 12'h000, 8'hFF);
                read_at(12'h000);
                read_at(12'h003);
                send(OP_WRITE, 12'h002, 8'h00);
                read_at(12'h002);
                send(OP_LOAD, 12'h003, 8'h5A);
                read_at(12'h003);
                read_at(12'hFFF);
            end else if (p == 3) begin
                // one set, byte blocks: fill all ways, then evict by use count
                read_at(12'h100);
                read_at(12'h101);
                read_at(12'h101);
                read_at(12'h102);
                read_at(12'h103);
                read_at(12'h104);
                read_at(12'h100);
            end

            while (n_sent < (p + 1) * ITEMS_TOTAL / PHASES) begin
                if (n_sent >= ITEMS_TOTAL - 150) quiet_tail = 1;
                random_item();
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (shadow.n_mismatch == 0 && shadow.pending() == 0) begin
            $display("PASS");
        end else begin
            if (shadow.pending() != 0)
                $display("%0d results never arrived", shadow.pending());
            $display("FAIL");
        end
        $finish;
    end
endmodule
